>>> design/kiss_ax25_frame_receiver_core_defines.svh
// Assertion macros for the KISS AX.25 frame receiver.
`ifndef KISS_AX25_FRAME_RECEIVER_CORE_DEFINES_SVH
`define KISS_AX25_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define KFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfr assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define KFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfr assertion failed");
`else
`define KFR_ASSERT_IMP(lbl, ante, cons)
`define KFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> design/kfr_pkg.sv
// Constants and types shared by the KISS AX.25 frame receiver.
package kfr_pkg;

  localparam int MAX_FRAME = 1024;
  localparam int CNT_BITS  = $clog2(MAX_FRAME + 1);
  localparam int CNT_W     = (CNT_BITS > 11) ? CNT_BITS : 11;

  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;
  localparam logic [7:0] CMD_DATA = 8'h00;
  localparam logic [7:0] BEACON_MARK = 8'hFF;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_OVERRUN = 2'd3;

  localparam logic [2:0] SEC_DEST = 3'd0;
  localparam logic [2:0] SEC_SRC  = 3'd1;
  localparam logic [2:0] SEC_CTRL = 3'd2;
  localparam logic [2:0] SEC_PID  = 3'd3;
  localparam logic [2:0] SEC_INFO = 3'd4;

  localparam logic [CNT_W-1:0] ADDR_END  = CNT_W'(14);
  localparam logic [CNT_W-1:0] DEST_END  = CNT_W'(7);
  localparam logic [CNT_W-1:0] PID_POS   = CNT_W'(15);
  localparam logic [CNT_W-1:0] INFO_POS  = CNT_W'(16);
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_FRAME);

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_ESC  = 4'b1000
  } phase_t;

endpackage

>>> design/kiss_ax25_frame_receiver_core.sv
// KISS deframer top level: unescapes AX.25 frames and tags each word.
// An accepted word's result is registered and shows at the outputs in the next
// cycle; words with no result (opening FEND, data command, FESC) only update state.
// Throughput: one word per cycle, set by the single result register; the input
// stalls only while that register holds a result the sink is stalling.
// Reset (rst, synchronous, active high): hunt for FEND, count and flag cleared.
`include "kiss_ax25_frame_receiver_core_defines.svh"

module kiss_ax25_frame_receiver_core
  import kfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic [2:0]  section,
  output logic [9:0]  position,
  output logic [10:0] frame_length,
  output logic        short_frame,
  output logic        beacon
);

  // Frame state.
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             beacon_seen, beacon_seen_next;

  // Result computed from the word being accepted.
  logic        emit;
  logic [1:0]  kind_next;
  logic [7:0]  value_next;
  logic [2:0]  section_next;
  logic [9:0]  position_next;
  logic [10:0] frame_length_next;
  logic        short_frame_next;
  logic        beacon_next;

  logic        take;
  logic        out_free;
  logic        do_decode;
  logic        do_end;
  logic [7:0]  dec_byte;

  // The result register frees when empty or when the sink takes it this cycle.
  assign out_free   = !result_valid || !result_stall;
  assign byte_stall = !out_free;
  assign take       = byte_valid && out_free;

  // Phase walk: pick what this word does.
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    beacon_seen_next = beacon_seen;
    emit             = 1'b0;
    do_decode        = 1'b0;
    do_end           = 1'b0;
    dec_byte         = in_byte;
    kind_next        = KIND_BYTE;
    value_next       = '0;
    section_next     = SEC_DEST;
    position_next    = '0;
    frame_length_next = '0;
    short_frame_next = 1'b0;
    beacon_next      = 1'b0;

    unique case (phase)
      PH_HUNT: begin
        if (in_byte == FEND) begin
          phase_next = PH_CMD;
        end else begin
          emit      = 1'b1;
          kind_next = KIND_REJECT;
        end
      end
      PH_CMD: begin
        if (in_byte == CMD_DATA) begin
          phase_next       = PH_DATA;
          byte_count_next  = '0;
          beacon_seen_next = 1'b0;
        end else begin
          phase_next = PH_HUNT;
          emit       = 1'b1;
          kind_next  = KIND_REJECT;
        end
      end
      PH_DATA: begin
        if (in_byte == FEND) begin
          do_end = 1'b1;
        end else if (in_byte == FESC) begin
          phase_next = PH_ESC;
        end else begin
          do_decode = 1'b1;
        end
      end
      PH_ESC: begin
        if (in_byte == FEND) begin
          // Drop the pending escape and close the frame.
          do_end = 1'b1;
        end else begin
          phase_next = PH_DATA;
          do_decode  = 1'b1;
          // Unknown escaped codes pass through unchanged.
          if (in_byte == TFEND) begin
            dec_byte = FEND;
          end else if (in_byte == TFESC) begin
            dec_byte = FESC;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    if (do_end) begin
      phase_next        = PH_HUNT;
      emit              = 1'b1;
      kind_next         = KIND_END;
      frame_length_next = byte_count[10:0];
      short_frame_next  = (byte_count < INFO_POS);
      beacon_next       = beacon_seen;
    end

    if (do_decode) begin
      emit = 1'b1;
      if (byte_count >= MAX_COUNT) begin
        // Frame full: report and drop the word, count holds.
        kind_next = KIND_OVERRUN;
      end else begin
        kind_next       = KIND_BYTE;
        position_next   = byte_count[9:0];
        byte_count_next = byte_count + CNT_W'(1);
        // Address callsign bytes arrive shifted left by one.
        value_next = (byte_count < ADDR_END) ? {1'b0, dec_byte[7:1]} : dec_byte;
        if (byte_count < DEST_END) begin
          section_next = SEC_DEST;
        end else if (byte_count < ADDR_END) begin
          section_next = SEC_SRC;
        end else if (byte_count == ADDR_END) begin
          section_next = SEC_CTRL;
        end else if (byte_count == PID_POS) begin
          section_next = SEC_PID;
        end else begin
          section_next = SEC_INFO;
        end
        if (byte_count == INFO_POS && dec_byte == BEACON_MARK) begin
          beacon_seen_next = 1'b1;
        end
      end
    end
  end

  // Advance state only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      beacon_seen <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      beacon_seen <= beacon_seen_next;
    end
  end

  // Result register: load when free, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      kind         <= kind_next;
      value        <= value_next;
      section      <= section_next;
      position     <= position_next;
      frame_length <= frame_length_next;
      short_frame  <= short_frame_next;
      beacon       <= beacon_next;
    end
  end

  // Checks on the frame logic.
  `KFR_ASSERT_IMP(a_count_bound, 1'b1, byte_count <= MAX_COUNT)
  `KFR_ASSERT_IMP(a_beacon_count, beacon_seen, byte_count > INFO_POS)
  `KFR_ASSERT_NXT(a_hunt_reject, take && phase == PH_HUNT && in_byte != FEND, result_valid && kind == KIND_REJECT)
  `KFR_ASSERT_IMP(a_nonbyte_zero, result_valid && kind != KIND_BYTE, value == 8'd0 && position == 10'd0 && section == SEC_DEST)

endmodule
